// File: rtl/icfu_pkg.sv
package icfu_pkg;

  // Field and register widths
  localparam int unsigned SIDE_W     = 6;
  localparam int unsigned THRESH_W   = 16;
  localparam int unsigned SEED_W     = 32;
  localparam int unsigned SIZE_W     = 11;
  localparam int unsigned CFG_DATA_W = 32;

  // Register reset values
  localparam logic [SIDE_W-1:0]   SIDE_RESET   = 6'd30;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 16'h8000;
  localparam logic [SEED_W-1:0]   SEED_DEFAULT = 32'd2463534242;
  localparam logic [SIZE_W-1:0]   SIZE_MAX     = 11'd2047;

  typedef enum logic [1:0] {
    OP_UPDATE = 2'd0,
    OP_READ   = 2'd1,
    OP_WRITE  = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    CFG_SIDE   = 2'd0,
    CFG_THRESH = 2'd1,
    CFG_TRI    = 2'd2,
    CFG_SEED   = 2'd3
  } cfg_idx_t;

  // Neighbor visiting order
  typedef enum logic [2:0] {
    DIR_DOWN       = 3'd0,
    DIR_UP         = 3'd1,
    DIR_RIGHT      = 3'd2,
    DIR_LEFT       = 3'd3,
    DIR_DOWN_RIGHT = 3'd4,
    DIR_UP_LEFT    = 3'd5
  } dir_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RDWAIT,
    ST_SEED,
    ST_ISSUE,
    ST_FETCH,
    ST_LOAD,
    ST_FINISH,
    ST_RESP
  } state_t;

  // Spin memory access request
  typedef struct packed {
    logic rd;
    logic wr;
    logic wdata;
  } spin_req_t;

  // Site queue control
  typedef struct packed {
    logic clr;
    logic push;
    logic pop;
  } queue_ctrl_t;

endpackage

// File: rtl/icfu_rng.sv
module icfu_rng import icfu_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  logic [SEED_W-1:0]   load_val,
  input  logic                step,
  output logic [THRESH_W-1:0] draw
);

  logic [SEED_W-1:0] state_r;
  logic [SEED_W-1:0] x1, x2, x3;

  // xorshift32; the draw is the upper half of the next state
  assign x1   = state_r ^ (state_r << 13);
  assign x2   = x1 ^ (x1 >> 17);
  assign x3   = x2 ^ (x2 << 5);
  assign draw = x3[SEED_W-1:SEED_W-THRESH_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEED_DEFAULT;
    end else if (load) begin
      // zero would lock the generator
      state_r <= (load_val == '0) ? SEED_DEFAULT : load_val;
    end else if (step) begin
      state_r <= x3;
    end
  end

endmodule

// File: rtl/icfu_spin_mem.sv
module icfu_spin_mem import icfu_pkg::*; #(
  parameter int unsigned AW = 10
) (
  input  logic          clk,
  input  logic          rst_n,
  input  spin_req_t     req,
  input  logic [AW-1:0] rd_addr,
  input  logic [AW-1:0] wr_addr,
  output logic          rdata,
  output logic          busy
);

  localparam int unsigned DEPTH = 1 << AW;

  logic          spin_mem [DEPTH];
  logic [AW-1:0] clr_cnt_r;
  logic          busy_r;
  logic          rd_data_r;
  logic          fwd_hit_r;
  logic          fwd_val_r;
  logic          we;
  logic [AW-1:0] wa;
  logic          wd;

  // Clearing pass owns the write port after reset
  assign we   = busy_r | req.wr;
  assign wa   = busy_r ? clr_cnt_r : wr_addr;
  assign wd   = busy_r ? 1'b0 : req.wdata;
  assign busy = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b1;
      clr_cnt_r <= '0;
      fwd_hit_r <= 1'b0;
    end else begin
      if (busy_r) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
        if (&clr_cnt_r) begin
          busy_r <= 1'b0;
        end
      end
      if (req.rd) begin
        fwd_hit_r <= we && (wa == rd_addr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      spin_mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd) begin
      rd_data_r <= spin_mem[rd_addr];
      fwd_val_r <= wd;
    end
  end

  // Same-cycle write to the read address wins
  assign rdata = fwd_hit_r ? fwd_val_r : rd_data_r;

endmodule

// File: rtl/icfu_site_queue.sv
module icfu_site_queue import icfu_pkg::*; #(
  parameter int unsigned AW = 10
) (
  input  logic          clk,
  input  logic          rst_n,
  input  queue_ctrl_t   ctrl,
  input  logic [AW-1:0] push_site,
  output logic [AW-1:0] pop_site,
  output logic          nonempty
);

  localparam int unsigned DEPTH = 1 << AW;

  logic [AW-1:0] queue_mem [DEPTH];
  logic [AW-1:0] head_r;
  logic [AW-1:0] tail_r;
  logic [AW-1:0] pop_data_r;

  assign nonempty = head_r < tail_r;
  assign pop_site = pop_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
    end else if (ctrl.clr) begin
      head_r <= '0;
      tail_r <= '0;
    end else begin
      if (ctrl.push) begin
        tail_r <= tail_r + AW'(1);
      end
      if (ctrl.pop) begin
        head_r <= head_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      queue_mem[tail_r] <= push_site;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.pop) begin
      pop_data_r <= queue_mem[head_r];
    end
  end

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.pop |-> nonempty)
    else $error("queue popped while empty");

endmodule

// File: rtl/ising_cluster_flip_update.sv
// Flow: a write or out-of-lattice item passes through RESP to out_valid, a read through
//   RDWAIT and RESP; an update through SEED, ISSUE over the D = 4 (square) or 6
//   (triangular) neighbors of each site, FETCH and LOAD per dequeued site, FINISH, RESP.
// Throughput: one item at a time; one spin-memory read per neighbor per cycle in ISSUE.
// Reset: synchronous, active low; config returns to reset values and a clearing pass over
//   the 2^(2*CW) entries (1024 at default) zeroes the spin memory, with in_stall high.
module ising_cluster_flip_update import icfu_pkg::*; #(
  parameter int unsigned MAX_SIDE = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_opcode,
  input  logic [4:0]            in_row,
  input  logic [4:0]            in_col,
  input  logic                  in_spin_in,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_spin_out,
  output logic [SIZE_W-1:0]     out_cluster_size,
  // configuration
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Coordinate and site widths; a site address is {row, col}
  localparam int unsigned CW    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int unsigned SW    = 2 * CW;
  localparam int unsigned SITES = MAX_SIDE * MAX_SIDE;
  localparam int unsigned CNTW  = $clog2(SITES + 1);
  localparam int unsigned SDW   = $clog2(MAX_SIDE + 1);
  localparam int unsigned EW    = (SDW > SIDE_W) ? SDW : SIDE_W;
  localparam int unsigned OW    = (CNTW > SIZE_W) ? CNTW : SIZE_W;

  // Configuration registers
  logic [SIDE_W-1:0]   side_r;
  logic [THRESH_W-1:0] thr_r;
  logic                tri_r;

  // Sequencer and datapath registers
  state_t              state_r,     state_nxt;
  logic [SW-1:0]       seed_addr_r, seed_addr_nxt;
  logic                seed_spin_r, seed_spin_nxt;
  logic [CW-1:0]       cur_row_r,   cur_row_nxt;
  logic [CW-1:0]       cur_col_r,   cur_col_nxt;
  dir_t                dir_r,       dir_nxt;
  logic [CNTW-1:0]     count_r,     count_nxt;
  logic                b_valid_r,   b_valid_nxt;
  logic [SW-1:0]       b_addr_r,    b_addr_nxt;
  logic [THRESH_W-1:0] b_draw_r,    b_draw_nxt;
  logic                res_spin_r,  res_spin_nxt;
  logic [SIZE_W-1:0]   res_size_r,  res_size_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_spin_r,  out_spin_nxt;
  logic [SIZE_W-1:0]   out_size_r,  out_size_nxt;

  // Submodule connections
  spin_req_t           spin_req;
  logic [SW-1:0]       spin_rd_addr;
  logic [SW-1:0]       spin_wr_addr;
  logic                spin_rdata;
  logic                mem_busy;
  queue_ctrl_t         q_ctrl;
  logic [SW-1:0]       q_pop_site;
  logic                q_nonempty;
  logic                rng_step;
  logic                rng_load;
  logic [THRESH_W-1:0] draw;

  // Combinational helpers
  logic [EW-1:0]       side_ext;
  logic [EW-1:0]       side_eff;
  logic                in_fire;
  logic                in_ok;
  logic [SW-1:0]       in_addr;
  logic [CW-1:0]       row_p1, row_m1, col_p1, col_m1;
  logic                dn_ok, up_ok, rt_ok, lf_ok;
  logic                nb_ok;
  logic [CW-1:0]       nb_row, nb_col;
  logic [SW-1:0]       nb_addr;
  logic                last_dir;
  logic                join_site;
  logic [OW-1:0]       size_ext;
  logic [SIZE_W-1:0]   size_sat;

  //--------------------------------------------------------------------------
  // Configuration: a seed write also reloads the generator
  //--------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r <= SIDE_RESET;
      thr_r  <= THRESH_RESET;
      tri_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SIDE:   side_r <= cfg_data[SIDE_W-1:0];
        CFG_THRESH: thr_r  <= cfg_data[THRESH_W-1:0];
        CFG_TRI:    tri_r  <= cfg_data[0];
        CFG_SEED:   ;
        default:    ;
      endcase
    end
  end

  assign rng_load = cfg_we && (cfg_idx_t'(cfg_index) == CFG_SEED);

  //--------------------------------------------------------------------------
  // Lattice geometry: clamp the side to [2, MAX_SIDE]
  //--------------------------------------------------------------------------
  assign side_ext = EW'(side_r);
  assign side_eff = (side_ext < EW'(2))        ? EW'(2) :
                    (side_ext > EW'(MAX_SIDE)) ? EW'(MAX_SIDE) : side_ext;

  assign in_fire = in_valid && !in_stall;
  assign in_ok   = (EW'(in_row) < side_eff) && (EW'(in_col) < side_eff);
  assign in_addr = {CW'(in_row), CW'(in_col)};

  // Open boundaries: a neighbor exists only inside the lattice
  assign row_p1 = cur_row_r + CW'(1);
  assign row_m1 = cur_row_r - CW'(1);
  assign col_p1 = cur_col_r + CW'(1);
  assign col_m1 = cur_col_r - CW'(1);
  assign dn_ok  = (EW'(cur_row_r) + EW'(1)) < side_eff;
  assign up_ok  = cur_row_r != '0;
  assign rt_ok  = (EW'(cur_col_r) + EW'(1)) < side_eff;
  assign lf_ok  = cur_col_r != '0;

  always_comb begin
    nb_ok  = 1'b0;
    nb_row = cur_row_r;
    nb_col = cur_col_r;
    unique case (dir_r)
      DIR_DOWN: begin
        nb_ok  = dn_ok;
        nb_row = row_p1;
      end
      DIR_UP: begin
        nb_ok  = up_ok;
        nb_row = row_m1;
      end
      DIR_RIGHT: begin
        nb_ok  = rt_ok;
        nb_col = col_p1;
      end
      DIR_LEFT: begin
        nb_ok  = lf_ok;
        nb_col = col_m1;
      end
      DIR_DOWN_RIGHT: begin
        nb_ok  = dn_ok && rt_ok;
        nb_row = row_p1;
        nb_col = col_p1;
      end
      DIR_UP_LEFT: begin
        nb_ok  = up_ok && lf_ok;
        nb_row = row_m1;
        nb_col = col_m1;
      end
      default: nb_ok = 1'b0;
    endcase
  end

  assign nb_addr  = {nb_row, nb_col};
  assign last_dir = tri_r ? (dir_r == DIR_UP_LEFT) : (dir_r == DIR_LEFT);

  //--------------------------------------------------------------------------
  // Resolve stage. Every visited site other than the seed has already been
  // flipped away from the seed spin, so "spin matches the seed's original
  // spin and the site is not the seed" is exactly "matching and unvisited".
  // This keeps the visited map implicit: it never needs a clearing pass.
  //--------------------------------------------------------------------------
  assign join_site = b_valid_r && (spin_rdata == seed_spin_r) && (b_draw_r < thr_r) &&
                     (b_addr_r != seed_addr_r) && (count_r < CNTW'(SITES));

  assign size_ext = OW'(count_r);
  assign size_sat = (size_ext > OW'(SIZE_MAX)) ? SIZE_MAX : size_ext[SIZE_W-1:0];

  //--------------------------------------------------------------------------
  // Sequencer: next state, memory requests and datapath updates
  //--------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    seed_addr_nxt = seed_addr_r;
    seed_spin_nxt = seed_spin_r;
    cur_row_nxt   = cur_row_r;
    cur_col_nxt   = cur_col_r;
    dir_nxt       = dir_r;
    count_nxt     = count_r;
    b_valid_nxt   = 1'b0;
    b_addr_nxt    = nb_addr;
    b_draw_nxt    = draw;
    res_spin_nxt  = res_spin_r;
    res_size_nxt  = res_size_r;
    // drop the result once the consumer takes it
    out_valid_nxt = out_valid_r && out_stall;
    out_spin_nxt  = out_spin_r;
    out_size_nxt  = out_size_r;
    spin_req      = '0;
    spin_rd_addr  = in_addr;
    spin_wr_addr  = in_addr;
    q_ctrl        = '0;
    rng_step      = 1'b0;

    // A joining neighbor flips, enters the queue and counts
    if (join_site) begin
      spin_req.wr    = 1'b1;
      spin_req.wdata = ~seed_spin_r;
      spin_wr_addr   = b_addr_r;
      q_ctrl.push    = 1'b1;
      count_nxt      = count_r + CNTW'(1);
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (!in_ok) begin
            // site outside the lattice: no change, no draw
            res_spin_nxt = 1'b0;
            res_size_nxt = '0;
            state_nxt    = ST_RESP;
          end else begin
            res_size_nxt = '0;
            case (opcode_t'(in_opcode))
              OP_UPDATE: begin
                spin_req.rd   = 1'b1;
                seed_addr_nxt = in_addr;
                cur_row_nxt   = CW'(in_row);
                cur_col_nxt   = CW'(in_col);
                state_nxt     = ST_SEED;
              end
              OP_WRITE: begin
                spin_req.wr    = 1'b1;
                spin_req.wdata = in_spin_in;
                res_spin_nxt   = in_spin_in;
                state_nxt      = ST_RESP;
              end
              default: begin
                // read, and the unused code acts as a read
                spin_req.rd = 1'b1;
                state_nxt   = ST_RDWAIT;
              end
            endcase
          end
        end
      end
      ST_RDWAIT: begin
        res_spin_nxt = spin_rdata;
        state_nxt    = ST_RESP;
      end
      ST_SEED: begin
        seed_spin_nxt = spin_rdata;
        count_nxt     = CNTW'(1);
        dir_nxt       = DIR_DOWN;
        q_ctrl.clr    = 1'b1;
        state_nxt     = ST_ISSUE;
      end
      ST_ISSUE: begin
        // one neighbor per cycle: read its spin and take a draw
        if (nb_ok) begin
          spin_req.rd  = 1'b1;
          spin_rd_addr = nb_addr;
          rng_step     = 1'b1;
          b_valid_nxt  = 1'b1;
        end
        if (last_dir) begin
          state_nxt = ST_FETCH;
        end else begin
          dir_nxt = dir_t'(dir_r + 3'd1);
        end
      end
      ST_FETCH: begin
        // hold until the last neighbor has resolved before calling the queue empty
        if (q_nonempty) begin
          q_ctrl.pop = 1'b1;
          state_nxt  = ST_LOAD;
        end else if (!b_valid_r) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_LOAD: begin
        cur_row_nxt = q_pop_site[SW-1:CW];
        cur_col_nxt = q_pop_site[CW-1:0];
        dir_nxt     = DIR_DOWN;
        state_nxt   = ST_ISSUE;
      end
      ST_FINISH: begin
        // the seed flips last
        spin_req.wr    = 1'b1;
        spin_req.wdata = ~seed_spin_r;
        spin_wr_addr   = seed_addr_r;
        res_spin_nxt   = ~seed_spin_r;
        res_size_nxt   = size_sat;
        state_nxt      = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_spin_nxt  = res_spin_r;
          out_size_nxt  = res_size_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      b_valid_r   <= b_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    seed_addr_r <= seed_addr_nxt;
    seed_spin_r <= seed_spin_nxt;
    cur_row_r   <= cur_row_nxt;
    cur_col_r   <= cur_col_nxt;
    dir_r       <= dir_nxt;
    count_r     <= count_nxt;
    b_addr_r    <= b_addr_nxt;
    b_draw_r    <= b_draw_nxt;
    res_spin_r  <= res_spin_nxt;
    res_size_r  <= res_size_nxt;
    out_spin_r  <= out_spin_nxt;
    out_size_r  <= out_size_nxt;
  end

  //--------------------------------------------------------------------------
  // Ports
  //--------------------------------------------------------------------------
  assign in_stall         = (state_r != ST_IDLE) || mem_busy;
  assign out_valid        = out_valid_r;
  assign out_spin_out     = out_spin_r;
  assign out_cluster_size = out_size_r;

  //--------------------------------------------------------------------------
  // Submodules
  //--------------------------------------------------------------------------
  icfu_spin_mem #(
    .AW(SW)
  ) u_spin_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (spin_req),
    .rd_addr (spin_rd_addr),
    .wr_addr (spin_wr_addr),
    .rdata   (spin_rdata),
    .busy    (mem_busy)
  );

  icfu_site_queue #(
    .AW(SW)
  ) u_site_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (q_ctrl),
    .push_site (b_addr_r),
    .pop_site  (q_pop_site),
    .nonempty  (q_nonempty)
  );

  icfu_rng u_rng (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (rng_load),
    .load_val (cfg_data[SEED_W-1:0]),
    .step     (rng_step),
    .draw     (draw)
  );

  //--------------------------------------------------------------------------
  // Assertions
  //--------------------------------------------------------------------------
  a_finish_drained: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FINISH |-> !b_valid_r)
    else $error("seed flipped while a neighbor was still resolving");

  a_join_in_growth: assert property (@(posedge clk) disable iff (!rst_n)
    join_site |-> (state_r == ST_ISSUE || state_r == ST_FETCH))
    else $error("neighbor joined outside cluster growth");

  a_resp_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RESP && (!out_valid_r || !out_stall)) |=>
      (out_valid_r && state_r == ST_IDLE))
    else $error("result not presented after response");

endmodule

// File: test/ising_cluster_flip_update_test.sv
module ising_cluster_flip_update_test;
  timeunit 1ns;
  timeprecision 1ps;

  import icfu_pkg::*;

  localparam int unsigned MAX_SIDE = 32;
  localparam int unsigned SITES = MAX_SIDE * MAX_SIDE;
  // opcode 3 has no enum member; the block treats it as a read
  localparam logic [1:0] OP_SPARE = 2'd3;
  // longer than the largest update on a small lattice, so a result is sure to back up
  localparam int unsigned LONG_HOLD = 2000;
  localparam int unsigned SETTLE_CYCLES = 8;

  typedef struct packed {
    logic              spin;
    logic [SIZE_W-1:0] size;
  } site_result_t;

  // Lattice mirror: spins, generator and registers, plus the results still owed by the block.
  class lattice_scoreboard;
    bit                spin[SITES];
    bit                visited[SITES];
    int unsigned       site_fifo[SITES];
    logic [31:0]       rng;
    logic [5:0]        side_reg;
    logic [15:0]       threshold;
    logic              tri_mode;
    site_result_t      awaited[$];
    int unsigned       errors;
    int unsigned       checked;
    int unsigned       updates;
    int unsigned       flipped_total;
    int unsigned       largest;
    // neighbor order: down, up, right, left, down-right, up-left
    int                step_row[6] = '{1, -1, 0, 0, 1, -1};
    int                step_col[6] = '{0, 0, 1, -1, 1, -1};

    function new();
      side_reg  = SIDE_RESET;
      threshold = THRESH_RESET;
      tri_mode  = 1'b0;
      rng       = SEED_DEFAULT;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_SIDE:   side_reg = value[5:0];
        CFG_THRESH: threshold = value[15:0];
        CFG_TRI:    tri_mode = value[0];
        CFG_SEED:   rng = (value == '0) ? SEED_DEFAULT : value;
        default:    ;
      endcase
    endfunction

    function int unsigned lattice_side();
      if (side_reg < 2) return 2;
      if (side_reg > MAX_SIDE) return MAX_SIDE;
      return side_reg;
    endfunction

    // xorshift32, draw is the upper half of the new state
    function logic [15:0] next_draw();
      logic [31:0] x;
      x = rng;
      x ^= x << 13;
      x ^= x >> 17;
      x ^= x << 5;
      rng = x;
      return x[31:16];
    endfunction

    function logic [SIZE_W-1:0] grow_cluster(int unsigned r0, int unsigned c0, int unsigned side);
      int unsigned seed_site;
      int unsigned head;
      int unsigned tail;
      int unsigned flipped;
      int unsigned dirs;
      int unsigned cur;
      int unsigned nb;
      int          nr;
      int          nc;
      bit          seed_spin;
      logic [15:0] draw;
      seed_site = r0 * MAX_SIDE + c0;
      seed_spin = spin[seed_site];
      head = 0;
      tail = 0;
      flipped = 1;
      dirs = tri_mode ? 6 : 4;
      site_fifo[tail++] = seed_site;
      visited[seed_site] = 1'b1;
      while (head < tail) begin
        cur = site_fifo[head++];
        for (int d = 0; d < dirs; d++) begin
          nr = int'(cur / MAX_SIDE) + step_row[d];
          nc = int'(cur % MAX_SIDE) + step_col[d];
          if (nr < 0 || nc < 0 || nr >= int'(side) || nc >= int'(side)) continue;
          nb = nr * MAX_SIDE + nc;
          draw = next_draw();
          if (spin[nb] == seed_spin && draw < threshold && !visited[nb] && tail < SITES) begin
            site_fifo[tail++] = nb;
            visited[nb] = 1'b1;
            spin[nb] = ~spin[nb];
            flipped++;
          end
        end
      end
      spin[seed_site] = ~spin[seed_site];
      foreach (visited[i]) visited[i] = 1'b0;
      return (flipped > SIZE_MAX) ? SIZE_MAX : flipped[SIZE_W-1:0];
    endfunction

    function void note_item(logic [1:0] op, logic [4:0] r, logic [4:0] c, logic s);
      site_result_t want;
      int unsigned  side;
      int unsigned  idx;
      want = '0;
      side = lattice_side();
      if (r < side && c < side) begin
        idx = r * MAX_SIDE + c;
        if (op == OP_UPDATE) begin
          want.size = grow_cluster(r, c, side);
          updates++;
          flipped_total += want.size;
          if (want.size > largest) largest = want.size;
        end else if (op == OP_WRITE) begin
          spin[idx] = s;
        end
        want.spin = spin[idx];
      end
      awaited.push_back(want);
    endfunction

    function void check_result(logic spin_got, logic [SIZE_W-1:0] size_got);
      site_result_t want;
      if (awaited.size() == 0) begin
        $error("unexpected result: spin_out %0d cluster_size %0d", spin_got, size_got);
        errors++;
        return;
      end
      want = awaited.pop_front();
      checked++;
      if (spin_got !== want.spin) begin
        $error("spin_out: expected %0d, got %0d", want.spin, spin_got);
        errors++;
      end
      if (size_got !== want.size) begin
        $error("cluster_size: expected %0d, got %0d", want.size, size_got);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [1:0]            in_opcode = OP_READ;
  logic [4:0]            in_row = '0;
  logic [4:0]            in_col = '0;
  logic                  in_spin_in = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_spin_out;
  logic [SIZE_W-1:0]     out_cluster_size;
  logic                  cfg_we = 1'b0;
  logic [1:0]            cfg_index = CFG_SIDE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  lattice_scoreboard sb = new();

  // Traffic shaping knobs, changed between phases by the stimulus.
  bit          tx_idle_on = 1'b1;
  bit          rx_idle_on = 1'b1;
  bit          long_hold_req = 1'b0;
  int unsigned burst_left = 0;
  int unsigned cur_side = SIDE_RESET;
  int unsigned phases = 0;

  ising_cluster_flip_update #(.MAX_SIDE(MAX_SIDE)) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_row           (in_row),
    .in_col           (in_col),
    .in_spin_in       (in_spin_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_spin_out     (out_spin_out),
    .out_cluster_size (out_cluster_size),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offer one item and hold it until the block takes it. Bursts of random length are
  // separated by random gaps unless idling is switched off for the phase.
  task automatic send_item(input logic [1:0] op, input logic [4:0] r, input logic [4:0] c,
                           input logic s);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = tx_idle_on ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid   <= 1'b1;
    in_opcode  <= op;
    in_row     <= r;
    in_col     <= c;
    in_spin_in <= s;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_item(op, r, c, s);
  endtask

  // Drop valid and wait until every owed result is back, then let the block settle.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    sb.write_reg(idx, value);
    @(posedge clk);
  endtask

  // Write all four registers while the block is idle; track the clamped side for stimulus.
  task automatic configure(input logic [CFG_DATA_W-1:0] side_v, input logic [CFG_DATA_W-1:0] thr_v,
                           input logic [CFG_DATA_W-1:0] tri_v, input logic [CFG_DATA_W-1:0] seed_v);
    drain();
    write_reg(CFG_SIDE, side_v);
    write_reg(CFG_THRESH, thr_v);
    write_reg(CFG_TRI, tri_v);
    write_reg(CFG_SEED, seed_v);
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_side = sb.lattice_side();
    phases++;
  endtask

  // Mostly in-lattice sites with a mix of all operations; a tenth of the sites anywhere
  // in the 5-bit range so that out-of-lattice items keep showing up. A requested receiver
  // hold starts once the registers are written, while items are being offered.
  task automatic random_phase(input int unsigned n_items, input bit full_size,
                              input bit hold_rx = 1'b0);
    logic [1:0]  op;
    logic [4:0]  r;
    logic [4:0]  c;
    int unsigned pick;
    // keep full-size lattices below the bond percolation point so updates stay short
    if (full_size)
      configure(MAX_SIDE, $urandom_range(0, 16000), $urandom_range(0, 1), $urandom());
    else
      configure($urandom_range(2, 12), $urandom_range(0, 65535), $urandom_range(0, 1), $urandom());
    if (hold_rx) long_hold_req = 1'b1;
    repeat (n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) op = OP_UPDATE;
      else if (pick < 70) op = OP_READ;
      else if (pick < 94) op = OP_WRITE;
      else op = OP_SPARE;
      if ($urandom_range(0, 9) == 0) begin
        r = 5'($urandom_range(0, 31));
        c = 5'($urandom_range(0, 31));
      end else begin
        r = 5'($urandom_range(0, cur_side - 1));
        c = 5'($urandom_range(0, cur_side - 1));
      end
      send_item(op, r, c, 1'($urandom_range(0, 1)));
    end
  endtask

  // Result side: alternate open and stalled runs; a requested long hold is counted here.
  initial begin : result_sink
    int unsigned run;
    bit          level;
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        run = LONG_HOLD;
        level = 1'b1;
      end else if (rx_idle_on && $urandom_range(0, 2) == 0) begin
        run = $urandom_range(1, 12);
        level = 1'b1;
      end else begin
        run = $urandom_range(1, 6);
        level = 1'b0;
      end
      repeat (run) begin
        @(negedge clk);
        out_stall <= level;
      end
    end
  end

  // Check every result the block hands over.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
      sb.check_result(out_spin_out, out_cluster_size);
  end

  initial begin : stimulus
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // hold off until the spin memory clearing pass is over
    do @(posedge clk); while (in_stall !== 1'b0);

    // Reset settings: single-spin access, spare opcode, out-of-lattice sites, first clusters.
    send_item(OP_READ, 5'd0, 5'd0, 1'b0);
    send_item(OP_WRITE, 5'd0, 5'd0, 1'b1);
    send_item(OP_READ, 5'd0, 5'd0, 1'b0);
    send_item(OP_SPARE, 5'd0, 5'd0, 1'b1);
    send_item(OP_READ, 5'd31, 5'd31, 1'b1);
    send_item(OP_WRITE, 5'd30, 5'd5, 1'b1);
    send_item(OP_UPDATE, 5'd5, 5'd30, 1'b0);
    send_item(OP_UPDATE, 5'd0, 5'd0, 1'b0);
    send_item(OP_WRITE, 5'd15, 5'd15, 1'b1);
    send_item(OP_UPDATE, 5'd15, 5'd15, 1'b0);

    // Smallest lattice, every bond accepted, diagonals on, zero seed replaced by the default.
    configure(2, 16'hFFFF, 1, 32'h0);
    send_item(OP_UPDATE, 5'd0, 5'd0, 1'b0);
    send_item(OP_UPDATE, 5'd1, 5'd1, 1'b0);
    send_item(OP_READ, 5'd1, 5'd0, 1'b0);
    send_item(OP_UPDATE, 5'd2, 5'd0, 1'b0);

    // Largest lattice, no bond accepted: clusters of the seed alone.
    configure(MAX_SIDE, 0, 0, 32'hFFFF_FFFF);
    send_item(OP_UPDATE, 5'd31, 5'd31, 1'b0);
    send_item(OP_WRITE, 5'd31, 5'd0, 1'b1);
    send_item(OP_UPDATE, 5'd31, 5'd0, 1'b0);
    send_item(OP_READ, 5'd31, 5'd31, 1'b0);

    // Side below range clamps up; wide side data is masked to six bits.
    configure(0, 40000, 1, 32'h1234_5678);
    send_item(OP_READ, 5'd2, 5'd2, 1'b0);
    send_item(OP_UPDATE, 5'd1, 5'd1, 1'b0);
    configure(32'hFFFF_FFC5, 50000, 0, 32'h0000_0001);
    send_item(OP_UPDATE, 5'd4, 5'd4, 1'b0);
    send_item(OP_READ, 5'd5, 5'd0, 1'b0);

    // Side above range clamps down; every bond accepted floods the whole lattice.
    configure(63, 16'hFFFF, 1, 32'h0000_0007);
    send_item(OP_UPDATE, 5'd0, 5'd0, 1'b0);
    send_item(OP_READ, 5'd31, 5'd31, 1'b0);

    random_phase(20, 1'b0);
    // long receiver hold while the sender keeps offering, so the input backs up
    tx_idle_on = 1'b0;
    random_phase(20, 1'b0, 1'b1);
    tx_idle_on = 1'b1;
    random_phase(20, 1'b1);
    // a stretch with no idling on either side
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    random_phase(20, 1'b0);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    random_phase(20, 1'b0);

    drain();
    $display("%0d results checked over %0d register settings; %0d cluster updates",
             sb.checked, phases + 1, sb.updates);
    $display("%0d spins flipped by clusters, largest cluster %0d sites",
             sb.flipped_total, sb.largest);
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("ising_cluster_flip_update_test: clean");
    end else begin
      $display("ising_cluster_flip_update_test: errors");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin : watchdog
    #40_000_000;
    $display("ising_cluster_flip_update_test: errors");
    $finish;
  end

endmodule
